@@ sv/bad_pkg.sv @@
// Shared types and constants for the block average downsampler.
// No dependencies; imported by bad_div and block_average_downsampler.
`timescale 1ns / 1ps
`default_nettype none

package bad_pkg;

  localparam int MAX_SIDE   = 512;
  localparam int PIXEL_BITS = 8;

  // Configuration register width and register indexes.
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIDE  = 1'd1;

  // Position counters hold 0..MAX_SIDE; the sum store is indexed by tile column.
  localparam int CNT_W = $clog2(MAX_SIDE + 1);
  localparam int IDX_W = $clog2(MAX_SIDE);

  // Accumulator and result widths.
  localparam int ACC_W     = 26;
  localparam int FRAC_BITS = 8;
  localparam int AVG_W     = 16;
  localparam int POS_W     = 9;

  // Shared divider; for the average, dividend is sum * 2^FRAC_BITS, divisor is block_side squared.
  localparam int DIV_N_W   = ACC_W + FRAC_BITS;
  localparam int DIV_D_W   = 2 * CFG_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

@@ sv/bad_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/bad_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the block.
// Depends on bad_pkg for operand widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module bad_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bad_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [bad_pkg::DIV_D_W-1:0] divisor,
  output logic      [bad_pkg::DIV_N_W-1:0] quotient,
  output bad_pkg::div_status_t             status
);
  import bad_pkg::*;

  logic [DIV_N_W-1:0]   num;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  assign trial = {rem, num[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in at the bottom as dividend bits leave the top.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_D_W'(trial - {1'b0, dsr});
        num <= {num[DIV_N_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_D_W-1:0];
        num <= {num[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assign quotient    = num;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

@@ sv/block_average_downsampler.sv @@
// Block average downsampler: box-average pooling over square tiles of a raster image.
// Depends on bad_pkg, bad_ram (tile sum store) and bad_div (shared divider).
// Flow: a pixel that closes no tile is read from the tile sum store on accept and written back
// in S_RMW; a pixel that closes a tile also runs the divider (34 quotient bits, then done), and
// S_PUT then loads the output register, waiting while a full output register is held.
// Reset: a clearing pass over all 512 sum store entries, then a tile count division; each
// configuration write likewise costs one tile count division before input is taken again.
`timescale 1ns / 1ps
`default_nettype none

module block_average_downsampler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [bad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bad_pkg::CFG_W-1:0]     cfg_data,
  // pixel input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bad_pkg::PIXEL_BITS-1:0] pixel,
  // tile result output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [bad_pkg::AVG_W-1:0]     average,
  output logic      [bad_pkg::POS_W-1:0]     out_row,
  output logic      [bad_pkg::POS_W-1:0]     out_col,
  output logic                               last
);
  import bad_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;  // sweep zeros through the sum store
  localparam logic [2:0] S_IDLE  = 3'd1;  // take a pixel or start a tile count division
  localparam logic [2:0] S_RMW   = 3'd2;  // sum store data back: add and write back
  localparam logic [2:0] S_ADIV  = 3'd3;  // average division running
  localparam logic [2:0] S_PUT   = 3'd4;  // move the quotient into the output register
  localparam logic [2:0] S_TDIV  = 3'd5;  // tile count division running

  logic [2:0] state;

  // Configuration and derived values.
  logic [CFG_W-1:0]   matrix_side;
  logic [CFG_W-1:0]   block_side;
  logic [CNT_W-1:0]   side_eff;
  logic [CFG_W-1:0]   blk_eff;
  logic [DIV_D_W-1:0] area;
  logic [CNT_W-1:0]   tiles;
  logic               tiles_dirty;

  // Position counters.
  logic [CNT_W-1:0] row_in_tile, tile_row, col_in_tile, tile_col;
  logic [CNT_W-1:0] image_row, image_col;
  logic [CNT_W-1:0] row_in_tile_next, tile_row_next, col_in_tile_next, tile_col_next;
  logic [CNT_W-1:0] image_row_next, image_col_next;
  logic [CNT_W:0]   cit, tc, ic, rit, tr, ir;

  // Pixel context carried from accept to write back.
  logic [PIXEL_BITS-1:0] px_q;
  logic [IDX_W-1:0]      idx_q;
  logic [POS_W-1:0]      row_q, col_q;
  logic                  in_range_q, emit_q, last_q;
  logic                  in_range, emit, is_last;

  // Sum store.
  logic [IDX_W-1:0] clr_addr;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [ACC_W-1:0] ram_wr_data, ram_rd_data;
  logic [ACC_W-1:0] sum;

  // Divider.
  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic [DIV_N_W-1:0] div_quot;
  div_status_t        div_st;

  logic accept;

  // Out-of-range sides behave as the nearest legal value.
  always_comb begin
    if (matrix_side == '0) begin
      side_eff = CNT_W'(1);
    end else if ({1'b0, matrix_side} > (CFG_W + 1)'(MAX_SIDE)) begin
      side_eff = CNT_W'(MAX_SIDE);
    end else begin
      side_eff = CNT_W'(matrix_side);
    end
    blk_eff = (block_side == '0) ? CFG_W'(1) : block_side;
  end

  // Configuration registers; any write forces the tile count to be recomputed.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_side <= CFG_W'(MAX_SIDE);
      block_side  <= CFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATRIX_SIDE: matrix_side <= cfg_data;
        REG_BLOCK_SIDE:  block_side  <= cfg_data;
      endcase
    end
  end

  // Tile area, registered ahead of the divider.
  always_ff @(posedge clk) begin
    area <= DIV_D_W'(blk_eff) * DIV_D_W'(blk_eff);
  end

  assign in_ready = (state == S_IDLE) && !tiles_dirty;
  assign accept   = in_valid && in_ready;

  // Classify the pixel at its current position.
  always_comb begin
    in_range = (tile_row < tiles) && (tile_col < tiles) && (tile_col < CNT_W'(MAX_SIDE));
    emit     = ({1'b0, row_in_tile} + 1'b1 >= (CNT_W + 1)'(blk_eff)) &&
               ({1'b0, col_in_tile} + 1'b1 >= (CNT_W + 1)'(blk_eff));
    is_last  = ({1'b0, tile_row} + 1'b1 == {1'b0, tiles}) &&
               ({1'b0, tile_col} + 1'b1 == {1'b0, tiles});
  end

  // Advance the raster position; wrap columns, then rows, then the frame.
  always_comb begin
    cit = {1'b0, col_in_tile} + 1'b1;
    tc  = {1'b0, tile_col};
    if (cit >= (CNT_W + 1)'(blk_eff)) begin
      cit = '0;
      tc  = {1'b0, tile_col} + 1'b1;
    end
    rit = {1'b0, row_in_tile};
    tr  = {1'b0, tile_row};
    ir  = {1'b0, image_row};
    ic  = {1'b0, image_col} + 1'b1;
    if (ic >= {1'b0, side_eff}) begin
      ic  = '0;
      cit = '0;
      tc  = '0;
      rit = {1'b0, row_in_tile} + 1'b1;
      if (rit >= (CNT_W + 1)'(blk_eff)) begin
        rit = '0;
        tr  = {1'b0, tile_row} + 1'b1;
      end
      ir = {1'b0, image_row} + 1'b1;
      if (ir >= {1'b0, side_eff}) begin
        ir  = '0;
        rit = '0;
        tr  = '0;
      end
    end
    // Hold tile indexes at the store depth.
    if (tc > (CNT_W + 1)'(MAX_SIDE)) begin
      tc = (CNT_W + 1)'(MAX_SIDE);
    end
    if (tr > (CNT_W + 1)'(MAX_SIDE)) begin
      tr = (CNT_W + 1)'(MAX_SIDE);
    end
    col_in_tile_next = cit[CNT_W-1:0];
    tile_col_next    = tc[CNT_W-1:0];
    image_col_next   = ic[CNT_W-1:0];
    row_in_tile_next = rit[CNT_W-1:0];
    tile_row_next    = tr[CNT_W-1:0];
    image_row_next   = ir[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_in_tile <= '0;
      tile_row    <= '0;
      col_in_tile <= '0;
      tile_col    <= '0;
      image_row   <= '0;
      image_col   <= '0;
    end else if (accept) begin
      row_in_tile <= row_in_tile_next;
      tile_row    <= tile_row_next;
      col_in_tile <= col_in_tile_next;
      tile_col    <= tile_col_next;
      image_row   <= image_row_next;
      image_col   <= image_col_next;
    end
  end

  // Capture the pixel and its tile context for the write-back cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      px_q       <= pixel;
      idx_q      <= tile_col[IDX_W-1:0];
      row_q      <= tile_row[POS_W-1:0];
      col_q      <= tile_col[POS_W-1:0];
      in_range_q <= in_range;
      emit_q     <= emit;
      last_q     <= is_last;
    end
  end

  // Sum store access: clear sweep, or read on accept and write back in the next cycle (S_RMW).
  assign sum         = ram_rd_data + ACC_W'(px_q);
  assign ram_re      = accept;
  assign ram_we      = (state == S_CLEAR) || ((state == S_RMW) && in_range_q);
  assign ram_wr_addr = (state == S_CLEAR) ? clr_addr : idx_q;
  assign ram_wr_data = ((state == S_CLEAR) || emit_q) ? '0 : sum;

  bad_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_SIDE)
  ) u_sums (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .re      (ram_re),
    .rd_addr (tile_col[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // One divider serves both the tile count (side / block) and the tile average.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {sum, FRAC_BITS'(0)};
    div_divisor  = area;
    if (state == S_IDLE && tiles_dirty) begin
      div_start    = 1'b1;
      div_dividend = DIV_N_W'(side_eff);
      div_divisor  = DIV_D_W'(blk_eff);
    end else if (state == S_RMW && in_range_q && emit_q) begin
      div_start = 1'b1;
    end
  end

  bad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_st)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      tiles       <= '0;
      tiles_dirty <= 1'b1;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(MAX_SIDE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (tiles_dirty) begin
            state <= S_TDIV;
          end else if (accept) begin
            state <= S_RMW;
          end
        end
        S_RMW: begin
          state <= (in_range_q && emit_q) ? S_ADIV : S_IDLE;
        end
        S_ADIV: begin
          if (div_st.done) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        S_TDIV: begin
          if (div_st.done) begin
            tiles <= div_quot[CNT_W-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // A write during the division wins and triggers another pass.
      if (cfg_we) begin
        tiles_dirty <= 1'b1;
      end else if (state == S_IDLE && tiles_dirty) begin
        tiles_dirty <= 1'b0;
      end
    end
  end

  // Output register: load once free, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && (!out_valid || out_ready)) begin
      average <= div_quot[AVG_W-1:0];
      out_row <= row_q;
      out_col <= col_q;
      last    <= last_q;
    end
  end

endmodule

`default_nettype wire
